// ===== design/eldf_pkg.sv =====
// shared types, register indexes and arithmetic helpers for the edge line deblocking filter
package eldf_pkg;

   localparam int unsigned PIX_W   = 8;
   localparam int unsigned BS_W    = 3;
   localparam int unsigned TC0_W   = 5;
   localparam int unsigned CSR_A_W = 3;
   localparam int unsigned CSR_D_W = 8;

   localparam logic [CSR_A_W-1:0] CSR_ALPHA     = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_BETA      = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_TC0_ONE   = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_TC0_TWO   = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_TC0_THREE = 3'd4;

   localparam logic [BS_W-1:0] BS_NONE   = 3'd0;
   localparam logic [BS_W-1:0] BS_ONE    = 3'd1;
   localparam logic [BS_W-1:0] BS_TWO    = 3'd2;
   localparam logic [BS_W-1:0] BS_THREE  = 3'd3;
   localparam logic [BS_W-1:0] BS_STRONG = 3'd4;

   typedef struct packed {
      logic [PIX_W-1:0] alpha;
      logic [PIX_W-1:0] beta;
      logic [TC0_W-1:0] tc0_one;
      logic [TC0_W-1:0] tc0_two;
      logic [TC0_W-1:0] tc0_three;
   } cfg_type;

   typedef struct packed {
      logic [BS_W-1:0]  bs;
      logic             chroma;
      logic [PIX_W-1:0] p3;
      logic [PIX_W-1:0] p2;
      logic [PIX_W-1:0] p1;
      logic [PIX_W-1:0] p0;
      logic [PIX_W-1:0] q0;
      logic [PIX_W-1:0] q1;
      logic [PIX_W-1:0] q2;
      logic [PIX_W-1:0] q3;
   } line_type;

   typedef struct packed {
      logic [PIX_W-1:0] p2;
      logic [PIX_W-1:0] p1;
      logic [PIX_W-1:0] p0;
      logic [PIX_W-1:0] q0;
      logic [PIX_W-1:0] q1;
      logic [PIX_W-1:0] q2;
      logic             filtered;
   } result_type;

   function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      if (a > b) begin
         return a - b;
      end
      return b - a;
   endfunction

   // zero extension into the signed working width of the normal filter
   function automatic logic signed [11:0] sx12(input logic [PIX_W-1:0] v);
      return signed'({4'b0000, v});
   endfunction

   // zero extension into the unsigned width of the strong filter sums
   function automatic logic [10:0] zx11(input logic [PIX_W-1:0] v);
      return {3'b000, v};
   endfunction

   function automatic logic signed [11:0] clip_sym(input logic signed [11:0] x,
                                                   input logic [5:0]         b);
      logic signed [11:0] bnd;
      bnd = signed'({6'b000000, b});
      if (x > bnd) begin
         return bnd;
      end
      if (x < -bnd) begin
         return -bnd;
      end
      return x;
   endfunction

   function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [11:0] x);
      if (x < 12'sd0) begin
         return '0;
      end
      if (x > 12'sd255) begin
         return 8'd255;
      end
      return x[PIX_W-1:0];
   endfunction

endpackage

// ===== design/eldf_csr.sv =====
// configuration registers: thresholds and clipping bounds
module eldf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [eldf_pkg::CSR_A_W-1:0]   wr_index,
   input  logic [eldf_pkg::CSR_D_W-1:0]   wr_data,
   output eldf_pkg::cfg_type              cfg
);
   import eldf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_ALPHA:     cfg_in.alpha     = wr_data;
            CSR_BETA:      cfg_in.beta      = wr_data;
            CSR_TC0_ONE:   cfg_in.tc0_one   = wr_data[TC0_W-1:0];
            CSR_TC0_TWO:   cfg_in.tc0_two   = wr_data[TC0_W-1:0];
            CSR_TC0_THREE: cfg_in.tc0_three = wr_data[TC0_W-1:0];
            // indexes past the last register are dropped
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/eldf_core.sv =====
// edge test, normal and strong filters for one pixel line
module eldf_core (
   input  eldf_pkg::cfg_type    cfg,
   input  eldf_pkg::line_type   line,
   output eldf_pkg::result_type result
);
   import eldf_pkg::*;

   logic [PIX_W-1:0]   ad_p0q0, ad_p1p0, ad_q1q0, ad_p2p0, ad_q2q0;
   logic               pass, ap, aq, small_step, strong_p, strong_q;
   logic [TC0_W-1:0]   tc0;
   logic [5:0]         tc;
   logic [8:0]         avg_sum;
   logic [PIX_W-1:0]   avg;
   logic signed [11:0] p1_raw, q1_raw, p1_corr, q1_corr, d_raw, delta;
   logic [PIX_W-1:0]   np1_norm, nq1_norm, np0_norm, nq0_norm;
   logic [10:0]        s_p, s_q, sp0, sp1, sp2, sq0, sq1, sq2, wp0, wq0;
   logic [7:0]         small_lim;

   always_comb begin
      ad_p0q0 = abs_diff(line.p0, line.q0);
      ad_p1p0 = abs_diff(line.p1, line.p0);
      ad_q1q0 = abs_diff(line.q1, line.q0);
      ad_p2p0 = abs_diff(line.p2, line.p0);
      ad_q2q0 = abs_diff(line.q2, line.q0);
      pass = (line.bs != BS_NONE) && (ad_p0q0 < cfg.alpha) &&
             (ad_p1p0 < cfg.beta) && (ad_q1q0 < cfg.beta);
      ap = ad_p2p0 < cfg.beta;
      aq = ad_q2q0 < cfg.beta;

      unique case (line.bs)
         BS_ONE:   tc0 = cfg.tc0_one;
         BS_TWO:   tc0 = cfg.tc0_two;
         BS_THREE: tc0 = cfg.tc0_three;
         default:  tc0 = '0;
      endcase

      // normal filter
      avg_sum = {1'b0, line.p0} + {1'b0, line.q0} + 9'd1;
      avg     = avg_sum[8:1];
      p1_raw  = sx12(line.p2) + sx12(avg) - (sx12(line.p1) <<< 1);
      q1_raw  = sx12(line.q2) + sx12(avg) - (sx12(line.q1) <<< 1);
      p1_corr = clip_sym(p1_raw >>> 1, {1'b0, tc0});
      q1_corr = clip_sym(q1_raw >>> 1, {1'b0, tc0});
      np1_norm = clamp_pix(sx12(line.p1) + p1_corr);
      nq1_norm = clamp_pix(sx12(line.q1) + q1_corr);

      if (line.chroma) begin
         tc = {1'b0, tc0} + 6'd1;
      end else begin
         tc = {1'b0, tc0} + {5'd0, ap} + {5'd0, aq};
      end
      d_raw = ((sx12(line.q0) - sx12(line.p0)) <<< 2) + sx12(line.p1) - sx12(line.q1)
              + 12'sd4;
      delta = clip_sym(d_raw >>> 3, tc);
      np0_norm = clamp_pix(sx12(line.p0) + delta);
      nq0_norm = clamp_pix(sx12(line.q0) - delta);

      // strong filter
      small_lim  = {2'b00, cfg.alpha[7:2]} + 8'd2;
      small_step = ad_p0q0 < small_lim;
      strong_p   = !line.chroma && small_step && ap;
      strong_q   = !line.chroma && small_step && aq;
      s_p = zx11(line.p1) + zx11(line.p0) + zx11(line.q0);
      s_q = zx11(line.p0) + zx11(line.q0) + zx11(line.q1);
      sp0 = (zx11(line.p2) + (s_p << 1) + zx11(line.q1) + 11'd4) >> 3;
      sp1 = (zx11(line.p2) + s_p + 11'd2) >> 2;
      sp2 = ((zx11(line.p3) << 1) + zx11(line.p2) + (zx11(line.p2) << 1) + s_p + 11'd4) >> 3;
      sq0 = (zx11(line.p1) + (s_q << 1) + zx11(line.q2) + 11'd4) >> 3;
      sq1 = (s_q + zx11(line.q2) + 11'd2) >> 2;
      sq2 = ((zx11(line.q3) << 1) + zx11(line.q2) + (zx11(line.q2) << 1) + s_q + 11'd4) >> 3;
      wp0 = ((zx11(line.p1) << 1) + zx11(line.p0) + zx11(line.q1) + 11'd2) >> 2;
      wq0 = ((zx11(line.q1) << 1) + zx11(line.q0) + zx11(line.p1) + 11'd2) >> 2;

      result.p2       = line.p2;
      result.p1       = line.p1;
      result.p0       = line.p0;
      result.q0       = line.q0;
      result.q1       = line.q1;
      result.q2       = line.q2;
      result.filtered = pass;

      if (pass) begin
         if (line.bs < BS_STRONG) begin
            result.p0 = np0_norm;
            result.q0 = nq0_norm;
            if (!line.chroma && ap) begin
               result.p1 = np1_norm;
            end
            if (!line.chroma && aq) begin
               result.q1 = nq1_norm;
            end
         end else begin
            if (strong_p) begin
               result.p0 = sp0[PIX_W-1:0];
               result.p1 = sp1[PIX_W-1:0];
               result.p2 = sp2[PIX_W-1:0];
            end else begin
               result.p0 = wp0[PIX_W-1:0];
            end
            if (strong_q) begin
               result.q0 = sq0[PIX_W-1:0];
               result.q1 = sq1[PIX_W-1:0];
               result.q2 = sq2[PIX_W-1:0];
            end else begin
               result.q0 = wq0[PIX_W-1:0];
            end
         end
      end
   end

endmodule

// ===== design/edge_line_deblock_filter_unit.sv =====
// edge line deblocking filter: input register, filter logic, result register
//
// One word on the req_ channel is one line of eight pixels p3..p0 | q0..q3 across
// a block edge, with its boundary strength and luma/chroma flag. Each accepted
// word gives exactly one word on the rsp_ channel: the six inner pixels after
// filtering and line_filtered, which is high when the edge test passed.
// A word is taken when valid is high and stall is low on that channel.
// A word accepted into the input register moves into the result register when the
// output is free and is then shown on rsp_. Throughput is one word per cycle while
// rsp_stall is low: the filter is a single pass of logic between the input
// and result registers.
// When rsp_stall is high the result holds and one more word is taken into the
// input register; req_stall rises only while both registers are full.
// The csr_ channel writes alpha_limit (0), beta_limit (1) and the tc0 bounds for
// strengths 1, 2 and 3 (2..4); it is always ready, and writes to other indexes
// are dropped. Write it only while no word is in flight.
// Synchronous reset empties both registers and clears all csr registers to zero.
module edge_line_deblock_filter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [eldf_pkg::BS_W-1:0]     req_boundary_strength,
   input  logic                          req_chroma_mode,
   input  logic [eldf_pkg::PIX_W-1:0]    req_pix_p3,
   input  logic [eldf_pkg::PIX_W-1:0]    req_pix_p2,
   input  logic [eldf_pkg::PIX_W-1:0]    req_pix_p1,
   input  logic [eldf_pkg::PIX_W-1:0]    req_pix_p0,
   input  logic [eldf_pkg::PIX_W-1:0]    req_pix_q0,
   input  logic [eldf_pkg::PIX_W-1:0]    req_pix_q1,
   input  logic [eldf_pkg::PIX_W-1:0]    req_pix_q2,
   input  logic [eldf_pkg::PIX_W-1:0]    req_pix_q3,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [eldf_pkg::PIX_W-1:0]    rsp_new_p2,
   output logic [eldf_pkg::PIX_W-1:0]    rsp_new_p1,
   output logic [eldf_pkg::PIX_W-1:0]    rsp_new_p0,
   output logic [eldf_pkg::PIX_W-1:0]    rsp_new_q0,
   output logic [eldf_pkg::PIX_W-1:0]    rsp_new_q1,
   output logic [eldf_pkg::PIX_W-1:0]    rsp_new_q2,
   output logic                          rsp_line_filtered,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [eldf_pkg::CSR_A_W-1:0]  csr_index,
   input  logic [eldf_pkg::CSR_D_W-1:0]  csr_data
);
   import eldf_pkg::*;

   cfg_type    cfg;
   line_type   line_ff, line_in;
   result_type res_ff, res_in;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_ready, in_load;

   assign csr_ready = 1'b1;

   eldf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   eldf_core u_core (
      .cfg    (cfg),
      .line   (line_ff),
      .result (res_in)
   );

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_ready;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      line_in = '{bs: req_boundary_strength, chroma: req_chroma_mode,
                  p3: req_pix_p3, p2: req_pix_p2, p1: req_pix_p1, p0: req_pix_p0,
                  q0: req_pix_q0, q1: req_pix_q1, q2: req_pix_q2, q3: req_pix_q3};
      in_valid_in  = in_load || (in_valid_ff && !out_ready);
      out_valid_in = out_ready ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         line_ff <= line_in;
      end
      if (out_ready && in_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_new_p2        = res_ff.p2;
   assign rsp_new_p1        = res_ff.p1;
   assign rsp_new_p0        = res_ff.p0;
   assign rsp_new_q0        = res_ff.q0;
   assign rsp_new_q1        = res_ff.q1;
   assign rsp_new_q2        = res_ff.q2;
   assign rsp_line_filtered = res_ff.filtered;

endmodule

// ===== design/eldf_checker.sv =====
// port level checks for the edge line deblocking filter, bound to the top level
module eldf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [eldf_pkg::PIX_W-1:0]    rsp_new_p2,
   input logic [eldf_pkg::PIX_W-1:0]    rsp_new_p1,
   input logic [eldf_pkg::PIX_W-1:0]    rsp_new_p0,
   input logic [eldf_pkg::PIX_W-1:0]    rsp_new_q0,
   input logic [eldf_pkg::PIX_W-1:0]    rsp_new_q1,
   input logic [eldf_pkg::PIX_W-1:0]    rsp_new_q2,
   input logic                          rsp_line_filtered
);
   import eldf_pkg::*;

   // a held result keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_filtered) &&
      $stable(rsp_new_p2) && $stable(rsp_new_p1) && $stable(rsp_new_p0) &&
      $stable(rsp_new_q0) && $stable(rsp_new_q1) && $stable(rsp_new_q2))
      else $error("rsp word changed while stalled");

   // input backs up only behind a full, stalled output
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

   // rsp_valid is high after every accepted line
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("accepted line did not reach the output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind edge_line_deblock_filter_unit eldf_checker u_eldf_checker (.*);

// ===== bench/edge_line_deblock_filter_unit_tb.sv =====
// self-checking testbench for the edge line deblocking filter unit
`timescale 1ns / 100ps

module edge_line_deblock_filter_unit_tb;
   import eldf_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_LINES   = 225;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [BS_W-1:0]      req_boundary_strength;
   logic                 req_chroma_mode;
   logic [PIX_W-1:0]     req_pix_p3;
   logic [PIX_W-1:0]     req_pix_p2;
   logic [PIX_W-1:0]     req_pix_p1;
   logic [PIX_W-1:0]     req_pix_p0;
   logic [PIX_W-1:0]     req_pix_q0;
   logic [PIX_W-1:0]     req_pix_q1;
   logic [PIX_W-1:0]     req_pix_q2;
   logic [PIX_W-1:0]     req_pix_q3;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PIX_W-1:0]     rsp_new_p2;
   logic [PIX_W-1:0]     rsp_new_p1;
   logic [PIX_W-1:0]     rsp_new_p0;
   logic [PIX_W-1:0]     rsp_new_q0;
   logic [PIX_W-1:0]     rsp_new_q1;
   logic [PIX_W-1:0]     rsp_new_q2;
   logic                 rsp_line_filtered;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_A_W-1:0]   csr_index;
   logic [CSR_D_W-1:0]   csr_data;

   // filter settings as the block should hold them
   int alpha_lim;
   int beta_lim;
   int tc0_tab [3];

   result_type pending_results [$];
   result_type oldest;

   int  mismatches;
   int  lines_sent;
   int  results_checked;
   int  lines_filtered;
   int  settings_used;
   int  cycle_count;
   int  rx_tick;
   int  burst_left;
   bit  steady_send;

   edge_line_deblock_filter_unit u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_boundary_strength (req_boundary_strength),
      .req_chroma_mode       (req_chroma_mode),
      .req_pix_p3            (req_pix_p3),
      .req_pix_p2            (req_pix_p2),
      .req_pix_p1            (req_pix_p1),
      .req_pix_p0            (req_pix_p0),
      .req_pix_q0            (req_pix_q0),
      .req_pix_q1            (req_pix_q1),
      .req_pix_q2            (req_pix_q2),
      .req_pix_q3            (req_pix_q3),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_new_p2            (rsp_new_p2),
      .rsp_new_p1            (rsp_new_p1),
      .rsp_new_p0            (rsp_new_p0),
      .rsp_new_q0            (rsp_new_q0),
      .rsp_new_q1            (rsp_new_q1),
      .rsp_new_q2            (rsp_new_q2),
      .rsp_line_filtered     (rsp_line_filtered),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: no progress after %0d cycles", $time, cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- filter math

   function automatic int pixel_dist(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic int limit_to(input int bound, input int x);
      if (x > bound) begin
         return bound;
      end
      if (x < -bound) begin
         return -bound;
      end
      return x;
   endfunction

   function automatic logic [PIX_W-1:0] sat_pixel(input int x);
      if (x < 0) begin
         return '0;
      end
      if (x > 255) begin
         return 8'd255;
      end
      return x[PIX_W-1:0];
   endfunction

   function automatic result_type filter_line(input line_type ln);
      result_type r;
      int p3, p2, p1, p0, q0, q1, q2, q3;
      int tc0, tc, delta, avg, s;
      bit ap, aq, near_edge;
      p3 = int'(ln.p3);
      p2 = int'(ln.p2);
      p1 = int'(ln.p1);
      p0 = int'(ln.p0);
      q0 = int'(ln.q0);
      q1 = int'(ln.q1);
      q2 = int'(ln.q2);
      q3 = int'(ln.q3);
      r.p2 = ln.p2;
      r.p1 = ln.p1;
      r.p0 = ln.p0;
      r.q0 = ln.q0;
      r.q1 = ln.q1;
      r.q2 = ln.q2;
      r.filtered = 1'b0;
      if (ln.bs == BS_NONE || pixel_dist(p0, q0) >= alpha_lim ||
          pixel_dist(p1, p0) >= beta_lim || pixel_dist(q1, q0) >= beta_lim) begin
         return r;
      end
      r.filtered = 1'b1;
      ap = pixel_dist(p2, p0) < beta_lim;
      aq = pixel_dist(q2, q0) < beta_lim;
      if (ln.bs < BS_STRONG) begin
         tc0 = tc0_tab[ln.bs - BS_ONE];
         tc  = tc0;
         if (ln.chroma) begin
            tc = tc0 + 1;
         end else begin
            avg = (p0 + q0 + 1) >>> 1;
            if (ap) begin
               r.p1 = sat_pixel(p1 + limit_to(tc0, (p2 + avg - 2 * p1) >>> 1));
               tc++;
            end
            if (aq) begin
               r.q1 = sat_pixel(q1 + limit_to(tc0, (q2 + avg - 2 * q1) >>> 1));
               tc++;
            end
         end
         // arithmetic shift on int floors negative sums
         delta = limit_to(tc, (4 * (q0 - p0) + (p1 - q1) + 4) >>> 3);
         r.p0 = sat_pixel(p0 + delta);
         r.q0 = sat_pixel(q0 - delta);
      end else begin
         near_edge = pixel_dist(p0, q0) < (alpha_lim >>> 2) + 2;
         if (!ln.chroma && near_edge && ap) begin
            s = p1 + p0 + q0;
            r.p0 = sat_pixel((p2 + 2 * s + q1 + 4) >>> 3);
            r.p1 = sat_pixel((p2 + s + 2) >>> 2);
            r.p2 = sat_pixel((2 * p3 + 3 * p2 + s + 4) >>> 3);
         end else begin
            r.p0 = sat_pixel((2 * p1 + p0 + q1 + 2) >>> 2);
         end
         if (!ln.chroma && near_edge && aq) begin
            s = p0 + q0 + q1;
            r.q0 = sat_pixel((p1 + 2 * s + q2 + 4) >>> 3);
            r.q1 = sat_pixel((s + q2 + 2) >>> 2);
            r.q2 = sat_pixel((2 * q3 + 3 * q2 + s + 4) >>> 3);
         end else begin
            r.q0 = sat_pixel((2 * q1 + q0 + p1 + 2) >>> 2);
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- result side

   // receiver stall pattern: quiet, sparse, periodic and heavy windows
   always @(negedge clock) begin
      rx_tick++;
      case ((rx_tick / 256) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ((rx_tick % 7) < 3);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                              input logic [PIX_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: result word expected none got p0 %0d q0 %0d", $time,
                     rsp_new_p0, rsp_new_q0);
         end else begin
            oldest = pending_results.pop_front();
            check_field("new_p2", oldest.p2, rsp_new_p2);
            check_field("new_p1", oldest.p1, rsp_new_p1);
            check_field("new_p0", oldest.p0, rsp_new_p0);
            check_field("new_q0", oldest.q0, rsp_new_q0);
            check_field("new_q1", oldest.q1, rsp_new_q1);
            check_field("new_q2", oldest.q2, rsp_new_q2);
            check_field("line_filtered", PIX_W'(oldest.filtered),
                        PIX_W'(rsp_line_filtered));
            results_checked++;
            if (oldest.filtered) begin
               lines_filtered++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- request side

   // called at a falling edge, returns at a falling edge
   task automatic send_line(input line_type ln);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid             <= 1'b1;
      req_boundary_strength <= ln.bs;
      req_chroma_mode       <= ln.chroma;
      req_pix_p3            <= ln.p3;
      req_pix_p2            <= ln.p2;
      req_pix_p1            <= ln.p1;
      req_pix_p0            <= ln.p0;
      req_pix_q0            <= ln.q0;
      req_pix_q1            <= ln.q1;
      req_pix_q2            <= ln.q2;
      req_pix_q3            <= ln.q3;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(filter_line(ln));
      lines_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_A_W-1:0] idx, input logic [CSR_D_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ALPHA: alpha_lim = int'(val);
         CSR_BETA: beta_lim = int'(val);
         CSR_TC0_ONE, CSR_TC0_TWO, CSR_TC0_THREE:
            tc0_tab[idx - CSR_TC0_ONE] = int'(val[TC0_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_config(input int alpha, input int beta, input int tc_one,
                               input int tc_two, input int tc_three);
      drain_pipeline();
      write_reg(CSR_ALPHA, CSR_D_W'(alpha));
      write_reg(CSR_BETA, CSR_D_W'(beta));
      write_reg(CSR_TC0_ONE, CSR_D_W'(tc_one));
      write_reg(CSR_TC0_TWO, CSR_D_W'(tc_two));
      write_reg(CSR_TC0_THREE, CSR_D_W'(tc_three));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // ---------------------------------------------------------------- random content

   function automatic logic [PIX_W-1:0] nudge(input int base, input int spread);
      int offset;
      offset = int'($urandom_range(0, 2 * spread)) - spread;
      return sat_pixel(base + offset);
   endfunction

   function automatic int pick_limit(input int top);
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 255;
         default: return $urandom_range(1, top);
      endcase
   endfunction

   function automatic int pick_clip();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom_range(0, 255);   // upper bits dropped by the block
         default: return $urandom_range(0, 25);
      endcase
   endfunction

   // mostly lines shaped to sit around the thresholds, some pure noise
   function automatic line_type random_line();
      line_type ln;
      int edge_spread;
      ln.bs     = BS_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << BS_W) - 1)
                                                    : $urandom_range(BS_ONE, BS_STRONG));
      ln.chroma = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
         {ln.p3, ln.p2, ln.p1, ln.p0, ln.q0, ln.q1, ln.q2, ln.q3} = {$urandom, $urandom};
      end else begin
         edge_spread = $urandom_range(0, 1) ? alpha_lim : (alpha_lim >>> 2) + 2;
         ln.p0 = PIX_W'($urandom_range(0, 255));
         ln.q0 = nudge(int'(ln.p0), edge_spread);
         ln.p1 = nudge(int'(ln.p0), beta_lim);
         ln.q1 = nudge(int'(ln.q0), beta_lim);
         ln.p2 = nudge(int'(ln.p0), beta_lim);
         ln.q2 = nudge(int'(ln.q0), beta_lim);
         ln.p3 = nudge(int'(ln.p2), 2 * beta_lim + 1);
         ln.q3 = nudge(int'(ln.q2), 2 * beta_lim + 1);
      end
      return ln;
   endfunction

   // ---------------------------------------------------------------- tests

   // all limits are zero after reset, so every line passes through
   task automatic test_reset_state();
      send_line(line_type'{BS_STRONG, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_line(line_type'{BS_ONE, 1'b1, 9, 10, 11, 12, 13, 14, 15, 16});
      send_line(line_type'{BS_NONE, 1'b0, 255, 255, 255, 255, 255, 255, 255, 255});
   endtask

   task automatic test_filter_modes();
      line_type ln;
      apply_config(255, 255, 0, 25, 8'hff);
      send_line(line_type'{BS_ONE, 1'b0, 40, 50, 60, 70, 90, 100, 110, 120});
      send_line(line_type'{BS_ONE, 1'b1, 40, 50, 60, 70, 90, 100, 110, 120});
      send_line(line_type'{BS_TWO, 1'b0, 0, 0, 0, 0, 254, 254, 254, 254});
      // p0 driven below zero
      send_line(line_type'{BS_TWO, 1'b0, 0, 0, 0, 2, 0, 250, 0, 0});
      send_line(line_type'{BS_THREE, 1'b0, 255, 250, 245, 240, 10, 5, 0, 0});
      send_line(line_type'{BS_THREE, 1'b1, 255, 250, 245, 240, 10, 5, 0, 0});
      // negative p1 correction term
      send_line(line_type'{BS_ONE, 1'b0, 0, 0, 200, 100, 100, 0, 0, 0});
      send_line(line_type'{BS_STRONG, 1'b0, 100, 102, 104, 106, 110, 112, 114, 116});
      send_line(line_type'{BS_STRONG, 1'b1, 100, 102, 104, 106, 110, 112, 114, 116});
      send_line(line_type'{BS_STRONG, 1'b0, 0, 20, 40, 60, 200, 210, 220, 230});
      send_line(line_type'{BS_STRONG, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_line(line_type'{BS_STRONG, 1'b0, 255, 255, 255, 255, 255, 255, 255, 255});
      send_line(line_type'{BS_NONE, 1'b0, 40, 50, 60, 70, 90, 100, 110, 120});
      // strengths above four take the strong path
      ln = line_type'{BS_STRONG, 1'b0, 100, 102, 104, 106, 110, 112, 114, 116};
      for (int s = BS_STRONG + 1; s < (1 << BS_W); s++) begin
         ln.bs     = BS_W'(s);
         ln.chroma = s[0];
         send_line(ln);
      end
   endtask

   task automatic test_thresholds();
      apply_config(20, 4, 5, 0, 13);
      // unused indexes must leave the settings alone
      for (int i = CSR_TC0_THREE + 1; i < (1 << CSR_A_W); i++) begin
         write_reg(CSR_A_W'(i), CSR_D_W'($urandom_range(0, 255)));
      end
      csr_valid <= 1'b0;
      send_line(line_type'{BS_ONE, 1'b0, 50, 52, 53, 55, 74, 75, 77, 80});
      send_line(line_type'{BS_ONE, 1'b0, 50, 52, 53, 55, 75, 75, 77, 80});
      send_line(line_type'{BS_TWO, 1'b0, 50, 40, 51, 55, 60, 62, 70, 80});
      send_line(line_type'{BS_THREE, 1'b0, 50, 40, 52, 55, 60, 62, 70, 80});
      send_line(line_type'{BS_THREE, 1'b1, 50, 40, 52, 55, 60, 62, 70, 80});
      send_line(line_type'{BS_STRONG, 1'b0, 50, 54, 55, 56, 62, 63, 64, 70});
      send_line(line_type'{BS_STRONG, 1'b0, 50, 54, 55, 56, 63, 64, 65, 70});
   endtask

   task automatic test_beta_zero();
      apply_config(255, 0, 25, 25, 25);
      send_line(line_type'{BS_TWO, 1'b0, 80, 80, 80, 80, 90, 90, 90, 90});
      send_line(line_type'{BS_STRONG, 1'b1, 80, 80, 80, 80, 80, 80, 80, 80});
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_config(pick_limit(255), pick_limit(40), pick_clip(), pick_clip(), pick_clip());
         steady_send = (phase % 3 == 1);
         repeat (PHASE_LINES) send_line(random_line());
      end
      steady_send = 1'b0;
   endtask

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_boundary_strength = '0;
      req_chroma_mode       = 1'b0;
      req_pix_p3            = '0;
      req_pix_p2            = '0;
      req_pix_p1            = '0;
      req_pix_p0            = '0;
      req_pix_q0            = '0;
      req_pix_q1            = '0;
      req_pix_q2            = '0;
      req_pix_q3            = '0;
      csr_valid             = 1'b0;
      csr_index             = '0;
      csr_data              = '0;
      alpha_lim             = 0;
      beta_lim              = 0;
      tc0_tab               = '{0, 0, 0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_filter_modes();
      test_thresholds();
      test_beta_zero();
      test_random_traffic();
      drain_pipeline();

      $display("%0d lines over %0d filter settings, %0d results checked, %0d of them filtered",
               lines_sent, settings_used, results_checked, lines_filtered);
      $display("strengths 0..7, luma and chroma, edge test limits and clip bounds exercised");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/eldf_pkg.sv
design/eldf_csr.sv
design/eldf_core.sv
design/edge_line_deblock_filter_unit.sv
design/eldf_checker.sv
bench/edge_line_deblock_filter_unit_tb.sv
